FILE: sv/valve_duty_from_neuron_activity_defines.svh
// Assertion macros shared by the valve duty controller modules.
`ifndef VALVE_DUTY_FROM_NEURON_ACTIVITY_DEFINES_SVH
`define VALVE_DUTY_FROM_NEURON_ACTIVITY_DEFINES_SVH
`ifndef SYNTHESIS
`define VDNA_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VDNA_CHECK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define VDNA_CHECK_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VDNA_CHECK(label, prop, msg)
`define VDNA_CHECK_IMP(label, ante, cons, msg)
`define VDNA_CHECK_NXT(label, ante, cons, msg)
`endif
`endif

FILE: sv/vdna_pkg.sv
// Types, constants and helper functions for the valve duty controller.
`default_nettype none
package vdna_pkg;

  localparam int LEGS         = 4;
  localparam int MUSCLES_EACH = 6;
  localparam int NUM_MUSCLES  = LEGS * MUSCLES_EACH;
  localparam int MAP_BITS     = 24;
  // Muscles that have a valve and per-muscle state.
  localparam int NSTATE       = (NUM_MUSCLES < MAP_BITS) ? NUM_MUSCLES : MAP_BITS;
  localparam int MIDX_W       = (NSTATE > 1) ? $clog2(NSTATE) : 1;

  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PMID   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd5;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_TWO  = 2'd2;
  localparam logic [1:0] MODE_FULL = 2'd3;

  typedef struct packed {
    logic [4:0]  muscle_index;
    logic [15:0] activation;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  valve_index;
    logic        valve_driven;
    logic        valve_open;
    logic [23:0] valve_map;
  } out_item_t;

  // Item after classification by the front end.
  typedef struct packed {
    logic     idx_ok;
    logic     boost_ok;
    in_item_t item;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  function automatic logic index_in_range(input logic [4:0] m);
    index_in_range = (int'(m) < NSTATE);
  endfunction

  // True for the first two muscles of every leg.
  function automatic logic boost_eligible(input logic [4:0] m);
    logic hit;
    hit = 1'b0;
    for (int l = 0; l < LEGS; l++) begin
      if (int'(m) == l * MUSCLES_EACH || int'(m) == l * MUSCLES_EACH + 1) hit = 1'b1;
    end
    boost_eligible = hit;
  endfunction

  function automatic logic slot_level(input logic [1:0] mode, input logic [1:0] slot);
    logic lv;
    case (mode)
      MODE_OFF: lv = 1'b0;
      MODE_ONE: lv = (slot == 2'd0);
      MODE_TWO: lv = (slot == 2'd0) || (slot == 2'd1);
      default:  lv = 1'b1;
    endcase
    slot_level = lv;
  endfunction

endpackage
`default_nettype wire

FILE: sv/vdna_front.sv
// Front end: accepts input transfers and classifies them for the back end.
`default_nettype none
module vdna_front (
  input  wire                 in_valid,
  output logic                in_stall,
  input  vdna_pkg::in_item_t  in_item,
  input  vdna_pkg::q_stat_t   q_stat,
  output logic                q_push,
  output vdna_pkg::q_item_t   q_wdata
);
  import vdna_pkg::*;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    q_wdata.item     = in_item;
    q_wdata.idx_ok   = index_in_range(in_item.muscle_index);
    q_wdata.boost_ok = boost_eligible(in_item.muscle_index);
  end

endmodule
`default_nettype wire

FILE: sv/vdna_queue.sv
// Short queue of classified items between the front and back ends.
`default_nettype none
`include "valve_duty_from_neuron_activity_defines.svh"
module vdna_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  vdna_pkg::q_item_t  wdata,
  input  wire                pop,
  output vdna_pkg::q_item_t  head,
  output vdna_pkg::q_stat_t  stat
);
  import vdna_pkg::*;

  q_item_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head          = mem_r[rd_ptr_r];
  assign stat.full     = (count_r == QCNT_W'(QDEPTH));
  assign stat.nonempty = (count_r != '0);

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  `VDNA_CHECK_IMP(a_no_push_full, push, !stat.full, "push into a full queue")
  `VDNA_CHECK_IMP(a_no_pop_empty, pop, stat.nonempty, "pop from an empty queue")
  `VDNA_CHECK(a_count_bound, count_r <= QCNT_W'(QDEPTH), "queue count out of range")

endmodule
`default_nettype wire

FILE: sv/vdna_back.sv
// Back end: per-muscle duty state, mode selection and the result register.
`default_nettype none
`include "valve_duty_from_neuron_activity_defines.svh"
module vdna_back (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire  [vdna_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [vdna_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  vdna_pkg::q_stat_t                    q_stat,
  input  vdna_pkg::q_item_t                    q_head,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output vdna_pkg::out_item_t                  out_item
);
  import vdna_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  // Configuration registers.
  logic [15:0] fire_th_r, plow_r, pmid_r, phigh_r, boost_th_r;
  logic [19:0] period_r;

  // Per-muscle state.
  logic [NSTATE-1:0] firing_r;
  logic [1:0]        mode_r [NSTATE];
  logic [1:0]        slot_r [NSTATE];
  logic [31:0]       sum_r  [NSTATE];
  logic [15:0]       cnt_r  [NSTATE];
  logic [31:0]       last_r [NSTATE];
  logic [NSTATE-1:0] valve_r;

  // Working copy of the item in flight.
  logic [1:0]  state_r;
  q_item_t     item_r;
  logic        w_fire_r, w_rel_r, w_tick_r;
  logic [1:0]  w_mode_r, w_slot_r;
  logic [31:0] w_sum_r;
  logic [15:0] w_cnt_r;
  logic [1:0]  k_r;
  logic [1:0]  lt_r;
  logic [31:0] prod_r;

  logic        out_valid_r;
  out_item_t   out_item_r;

  logic [MIDX_W-1:0] m;
  logic [15:0]       a;
  logic              f0, start, f1, rel, tick, choose;
  logic [1:0]        mode1, slot1, mode2, slot2;
  logic [32:0]       sum_add;
  logic [31:0]       sum1;
  logic [15:0]       cnt1;
  logic [31:0]       elapsed;
  logic [15:0]       mul_thr;
  logic              lt_now;
  logic [1:0]        chosen;
  logic              wb_go, level;
  logic [NSTATE-1:0] valve_nxt;

  assign m = item_r.item.muscle_index[MIDX_W-1:0];
  assign a = item_r.item.activation;

  // Evaluation of one sample against the muscle's stored state.
  always_comb begin
    f0      = item_r.idx_ok && firing_r[m];
    start   = item_r.idx_ok && !f0 && (a >= fire_th_r);
    f1      = f0 || start;
    mode1   = start ? MODE_FULL : mode_r[m];
    slot1   = start ? 2'd0 : slot_r[m];
    sum_add = {1'b0, sum_r[m]} + {17'd0, a};
    sum1    = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
    cnt1    = (cnt_r[m] == 16'hFFFF) ? cnt_r[m] : cnt_r[m] + 16'd1;
    rel     = f1 && (a < fire_th_r);
    mode2   = mode1;
    slot2   = slot1;
    if (f1 && !rel && item_r.boost_ok && (a >= boost_th_r)) begin
      mode2 = MODE_FULL;
      slot2 = 2'd0;
    end
    elapsed = item_r.item.now_time - last_r[m];
    tick    = f1 && !rel && (elapsed > {12'd0, period_r});
    choose  = tick && (slot2 == 2'd3);
  end

  always_comb begin
    case (k_r)
      2'd0:    mul_thr = plow_r;
      2'd1:    mul_thr = pmid_r;
      default: mul_thr = phigh_r;
    endcase
  end

  // The product of the third threshold is compared in the last step.
  assign lt_now = (w_sum_r < prod_r);

  always_comb begin
    if (lt_r[0])     chosen = MODE_OFF;
    else if (lt_r[1]) chosen = MODE_ONE;
    else if (lt_now)  chosen = MODE_TWO;
    else              chosen = MODE_FULL;
  end

  assign wb_go = (state_r == S_WB) && (!out_valid_r || !out_stall);
  assign level = slot_level(w_mode_r, w_slot_r);
  assign q_pop = (state_r == S_IDLE) && q_stat.nonempty;

  always_comb begin
    valve_nxt = valve_r;
    if (w_rel_r)       valve_nxt[m] = 1'b0;
    else if (w_tick_r) valve_nxt[m] = level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fire_th_r  <= 16'd32768;
      plow_r     <= 16'd16384;
      pmid_r     <= 16'd32768;
      phigh_r    <= 16'd49152;
      boost_th_r <= 16'd9830;
      period_r   <= 20'd17000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRE:   fire_th_r  <= cfg_data[15:0];
        CFG_PLOW:   plow_r     <= cfg_data[15:0];
        CFG_PMID:   pmid_r     <= cfg_data[15:0];
        CFG_PHIGH:  phigh_r    <= cfg_data[15:0];
        CFG_BOOST:  boost_th_r <= cfg_data[15:0];
        CFG_PERIOD: period_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Working registers are payload and need no reset.
  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_head;
    unique case (state_r)
      S_EVAL: begin
        w_fire_r <= f1 && !rel;
        w_rel_r  <= rel;
        w_tick_r <= tick;
        w_mode_r <= rel ? MODE_OFF : mode2;
        w_slot_r <= slot2;
        w_sum_r  <= rel ? 32'd0 : (f1 ? sum1 : sum_r[m]);
        w_cnt_r  <= rel ? 16'd0 : (f1 ? cnt1 : cnt_r[m]);
      end
      S_MUL: begin
        if (k_r != 2'd3) prod_r <= {16'd0, mul_thr} * {16'd0, w_cnt_r};
        if (k_r == 2'd1) lt_r[0] <= lt_now;
        if (k_r == 2'd2) lt_r[1] <= lt_now;
        if (k_r == 2'd3) begin
          w_mode_r <= chosen;
          w_slot_r <= 2'd0;
          w_sum_r  <= 32'd0;
          w_cnt_r  <= 16'd0;
        end
      end
      default: ;
    endcase
    if (wb_go) begin
      out_item_r.valve_index  <= item_r.item.muscle_index;
      out_item_r.valve_driven <= w_rel_r || w_tick_r;
      out_item_r.valve_open   <= w_tick_r && level;
      out_item_r.valve_map    <= 24'(valve_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
      firing_r    <= '0;
      valve_r     <= '0;
      for (int i = 0; i < NSTATE; i++) begin
        mode_r[i] <= MODE_OFF;
        slot_r[i] <= 2'd0;
        sum_r[i]  <= 32'd0;
        cnt_r[i]  <= 16'd0;
        last_r[i] <= 32'd0;
      end
    end else begin
      if (wb_go)                          out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (q_pop) state_r <= S_EVAL;
        S_EVAL: begin
          k_r     <= 2'd0;
          state_r <= choose ? S_MUL : S_WB;
        end
        S_MUL: begin
          k_r <= k_r + 2'd1;
          if (k_r == 2'd3) state_r <= S_WB;
        end
        S_WB: begin
          if (wb_go) begin
            state_r <= S_IDLE;
            if (item_r.idx_ok) begin
              firing_r[m] <= w_fire_r;
              mode_r[m]   <= w_mode_r;
              sum_r[m]    <= w_sum_r;
              cnt_r[m]    <= w_cnt_r;
              slot_r[m]   <= w_tick_r ? w_slot_r + 2'd1 : w_slot_r;
              if (w_tick_r) last_r[m] <= item_r.item.now_time;
              valve_r     <= valve_nxt;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `VDNA_CHECK(a_valve_needs_firing, (valve_r & ~firing_r) == '0,
              "valve open on a muscle that is not firing")
  `VDNA_CHECK_NXT(a_wb_returns_idle, wb_go, state_r == S_IDLE,
                  "write-back did not return to idle")
  `VDNA_CHECK_NXT(a_mul_ends, (state_r == S_MUL) && (k_r == 2'd3), state_r == S_WB,
                  "mode selection did not finish in four steps")

endmodule
`default_nettype wire

FILE: sv/valve_duty_from_neuron_activity.sv
// Top level of the valve duty controller driven by motor-neuron activity.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  muscle_index, activation, now_time
//   out_     output     out_valid/out_stall valve_index, valve_driven, valve_open, valve_map
//   cfg_     input      cfg_we             cfg_index, cfg_data
//
// In the back end each sample is popped, evaluated and written back, with mode
// selection when a mode is chosen again: the three threshold products share one
// 16x16 multiplier over four steps. A two-entry queue lets the input side run ahead.
// Reset is synchronous and clears all muscle state at once; no clearing pass.
// A stalled result holds the back end in write-back; the queue then fills and
// stalls the input.
`default_nettype none
module valve_duty_from_neuron_activity (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  vdna_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  wire                              out_stall,
  output vdna_pkg::out_item_t              out_item,
  input  wire                              cfg_we,
  input  wire  [vdna_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [vdna_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import vdna_pkg::*;

  q_stat_t q_stat;
  q_item_t q_wdata, q_head;
  logic    q_push, q_pop;

  vdna_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  vdna_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  vdna_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
